[rtl/bpd_pkg.sv]
`default_nettype none

package bpd_pkg;

  localparam int unsigned CAPACITY_DEF = 256;
  localparam int unsigned KIND_W       = 3;
  localparam int unsigned COORD_W      = 8;
  localparam int unsigned IDX_W        = 8;
  localparam int unsigned CNT_W        = 9;

  typedef enum logic [KIND_W-1:0] {
    KIND_INS_HEAD = 3'd0,
    KIND_INS_TAIL = 3'd1,
    KIND_REM_HEAD = 3'd2,
    KIND_REM_TAIL = 3'd3,
    KIND_RD_INDEX = 3'd4,
    KIND_RD_TAIL  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [COORD_W-1:0] symbol;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } entry_t;

  // Result of one operation waiting for its read data
  typedef struct packed {
    logic             rd;
    status_e          status;
    logic [CNT_W-1:0] count;
  } pend_t;

endpackage

`default_nettype wire

[rtl/bpd_if.sv]
`default_nettype none

interface bpd_in_if;
  logic                          valid;
  logic                          ready;
  logic [bpd_pkg::KIND_W-1:0]    kind;
  logic [bpd_pkg::COORD_W-1:0]   pos_x;
  logic [bpd_pkg::COORD_W-1:0]   pos_y;
  logic [bpd_pkg::COORD_W-1:0]   pos_symbol;
  logic [bpd_pkg::IDX_W-1:0]     index;

  modport source (output valid, kind, pos_x, pos_y, pos_symbol, index, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, pos_symbol, index, output ready);
endinterface

interface bpd_out_if;
  logic                          valid;
  logic                          ready;
  logic [bpd_pkg::COORD_W-1:0]   out_x;
  logic [bpd_pkg::COORD_W-1:0]   out_y;
  logic [bpd_pkg::COORD_W-1:0]   out_symbol;
  logic [1:0]                    status;
  logic [bpd_pkg::CNT_W-1:0]     entry_count;

  modport source (output valid, out_x, out_y, out_symbol, status, entry_count, input ready);
  modport sink   (input valid, out_x, out_y, out_symbol, status, entry_count, output ready);
endinterface

`default_nettype wire

[rtl/bounded_position_deque.sv]
// Bounded double-ended queue of position entries (x, y, symbol).
// Input channel in_i carries one operation per beat: insert at head or tail,
// remove head or tail, read the entry at an index from the head, or read the
// tail. Output channel out_o returns exactly one result beat per operation:
// the entry read (zero for other operations), a status code and the number
// of entries held after the operation.
// Entries sit in a single-port-write, single-port-read synchronous RAM of
// CAPACITY words used as a ring addressed from a head pointer.
// A result is registered in the pending stage, alongside the RAM read word,
// and then in the output register.
// Throughput: one operation per cycle while out_o is not stalled; each
// operation makes at most one RAM access, so the RAM port sets the rate.
// Reset empties the queue (head and count to zero); RAM contents are left
// as they are and are never read before being written.
// A stalled receiver holds the result in the output register; one more
// operation is taken into the pending stage, after which in_i.ready drops.
`default_nettype none

module bounded_position_deque #(
  parameter int unsigned CAPACITY = bpd_pkg::CAPACITY_DEF
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  bpd_in_if.sink         in_i,
  bpd_out_if.source      out_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  bpd_pkg::entry_t  wdata, rdata;
  logic             pend_valid, pend_take;
  bpd_pkg::pend_t   pend;

  logic                       out_valid_q;
  bpd_pkg::entry_t            out_entry_q;
  logic [1:0]                 out_status_q;
  logic [bpd_pkg::CNT_W-1:0]  out_count_q;

  assign wdata.x      = in_i.pos_x;
  assign wdata.y      = in_i.pos_y;
  assign wdata.symbol = in_i.pos_symbol;

  bpd_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .kind_i       (in_i.kind),
    .index_i      (in_i.index),
    .we_o         (we),
    .waddr_o      (waddr),
    .re_o         (re),
    .raddr_o      (raddr),
    .pend_valid_o (pend_valid),
    .pend_o       (pend),
    .pend_take_i  (pend_take)
  );

  bpd_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Advance the pending result whenever the output register is free or drains
  assign pend_take = pend_valid && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pend_take) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_take) begin
      out_entry_q  <= pend.rd ? rdata : '0;
      out_status_q <= pend.status;
      out_count_q  <= pend.count;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_x       = out_entry_q.x;
  assign out_o.out_y       = out_entry_q.y;
  assign out_o.out_symbol  = out_entry_q.symbol;
  assign out_o.status      = out_status_q;
  assign out_o.entry_count = out_count_q;

endmodule

`default_nettype wire

[rtl/bpd_ram.sv]
`default_nettype none

module bpd_ram #(
  parameter int unsigned DEPTH = bpd_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire                  clk_i,
  input  wire                  we_i,
  input  wire  [AW-1:0]        waddr_i,
  input  bpd_pkg::entry_t      wdata_i,
  input  wire                  re_i,
  input  wire  [AW-1:0]        raddr_i,
  output bpd_pkg::entry_t      rdata_o
);

  bpd_pkg::entry_t mem_q [DEPTH];
  bpd_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold the read word until the next read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/bpd_ctrl.sv]
`default_nettype none

module bpd_ctrl #(
  parameter int unsigned CAPACITY = bpd_pkg::CAPACITY_DEF,
  parameter int unsigned AW       = $clog2(CAPACITY),
  parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  [bpd_pkg::KIND_W-1:0]   kind_i,
  input  wire  [bpd_pkg::IDX_W-1:0]    index_i,
  output logic                         we_o,
  output logic [AW-1:0]                waddr_o,
  output logic                         re_o,
  output logic [AW-1:0]                raddr_o,
  output logic                         pend_valid_o,
  output bpd_pkg::pend_t               pend_o,
  input  wire                          pend_take_i
);

  localparam int unsigned IW = (CW > bpd_pkg::IDX_W) ? CW : bpd_pkg::IDX_W;
  localparam int unsigned SW = IW + 1;

  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic             pend_valid_q;
  bpd_pkg::pend_t   pend_q, pend_d;
  logic             accept;
  logic             full, empty;
  logic [IW-1:0]    idx_w, count_w;

  // Ring slot of the entry at an offset from the head; correct for an offset below CAPACITY
  function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] head,
                                              input logic [SW-1:0] offset);
    logic [SW-1:0] sum;
    sum = SW'(head) + offset;
    if (sum >= SW'(CAPACITY)) begin
      sum = sum - SW'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  assign in_ready_o = !pend_valid_q || pend_take_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CW'(CAPACITY));
  assign empty      = (count_q == '0);
  assign idx_w      = IW'(index_i);
  assign count_w    = IW'(count_q);

  always_comb begin
    head_d         = head_q;
    count_d        = count_q;
    we_o           = 1'b0;
    waddr_o        = ring_slot(head_q, SW'(count_q));
    re_o           = 1'b0;
    raddr_o        = ring_slot(head_q, SW'(idx_w));
    pend_d.rd      = 1'b0;
    pend_d.status  = bpd_pkg::ST_DONE;
    unique case (bpd_pkg::kind_e'(kind_i))
      bpd_pkg::KIND_INS_HEAD: begin
        if (full) begin
          pend_d.status = bpd_pkg::ST_FULL;
        end else begin
          head_d  = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - 1'b1;
          we_o    = accept;
          waddr_o = head_d;
          count_d = count_q + 1'b1;
        end
      end
      bpd_pkg::KIND_INS_TAIL: begin
        if (full) begin
          pend_d.status = bpd_pkg::ST_FULL;
        end else begin
          we_o    = accept;
          count_d = count_q + 1'b1;
        end
      end
      bpd_pkg::KIND_REM_HEAD: begin
        if (empty) begin
          pend_d.status = bpd_pkg::ST_EMPTY;
        end else begin
          head_d  = ring_slot(head_q, SW'(1));
          count_d = count_q - 1'b1;
        end
      end
      bpd_pkg::KIND_REM_TAIL: begin
        if (empty) begin
          pend_d.status = bpd_pkg::ST_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      bpd_pkg::KIND_RD_INDEX: begin
        if (empty) begin
          pend_d.status = bpd_pkg::ST_EMPTY;
        end else if (idx_w >= count_w) begin
          pend_d.status = bpd_pkg::ST_RANGE;
        end else begin
          re_o      = accept;
          pend_d.rd = 1'b1;
        end
      end
      bpd_pkg::KIND_RD_TAIL: begin
        if (empty) begin
          pend_d.status = bpd_pkg::ST_EMPTY;
        end else begin
          re_o      = accept;
          raddr_o   = ring_slot(head_q, SW'(count_q - 1'b1));
          pend_d.rd = 1'b1;
        end
      end
      default: begin
      end
    endcase
    pend_d.count = bpd_pkg::CNT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
    end else if (accept) begin
      head_q       <= head_d;
      count_q      <= count_d;
      pend_valid_q <= 1'b1;
    end else if (pend_take_i) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= pend_d;
    end
  end

  assign pend_valid_o = pend_valid_q;
  assign pend_o       = pend_q;

endmodule

`default_nettype wire

[rtl/bpd_checker.sv]
`default_nettype none

module bpd_checker #(
  parameter int unsigned CAPACITY = bpd_pkg::CAPACITY_DEF
) (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          out_valid_i,
  input wire                          out_ready_i,
  input wire [bpd_pkg::COORD_W-1:0]   out_x_i,
  input wire [bpd_pkg::COORD_W-1:0]   out_y_i,
  input wire [bpd_pkg::COORD_W-1:0]   out_symbol_i,
  input wire [1:0]                    status_i,
  input wire [bpd_pkg::CNT_W-1:0]     entry_count_i
);

  // Stalled result beat holds its valid, status, count and x
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(entry_count_i) && $stable(out_x_i))
    else $error("stalled result beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == bpd_pkg::ST_FULL
      |-> entry_count_i == bpd_pkg::CNT_W'(CAPACITY))
    else $error("full status with count below capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == bpd_pkg::ST_EMPTY |-> entry_count_i == '0)
    else $error("empty status with entries held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != bpd_pkg::ST_DONE
      |-> out_x_i == '0 && out_y_i == '0 && out_symbol_i == '0)
    else $error("flagged result carries data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> CAPACITY > 511 || entry_count_i <= bpd_pkg::CNT_W'(CAPACITY))
    else $error("count beyond capacity");

endmodule

bind bounded_position_deque bpd_checker #(
  .CAPACITY (CAPACITY)
) u_bpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_x_i       (out_o.out_x),
  .out_y_i       (out_o.out_y),
  .out_symbol_i  (out_o.out_symbol),
  .status_i      (out_o.status),
  .entry_count_i (out_o.entry_count)
);

`default_nettype wire
